@@ hw/rtl/gbr_pkg.sv @@
// Shared constants, types and kernel table for the 5x5 Gaussian blur core.
`timescale 1ns / 1ps

package gbr_pkg;

	// Line geometry and pixel packing
	localparam int MAX_LINE    = 1024;
	localparam int LINE_AW     = $clog2(MAX_LINE);
	localparam int KSIDE       = 5;
	localparam int STORE_LINES = KSIDE - 1;
	localparam int NCHAN       = 4;
	localparam int CH_W        = 8;
	localparam int PIX_W       = NCHAN * CH_W;
	localparam int STORE_W     = STORE_LINES * PIX_W;

	// Configuration and frame counters
	localparam int WIDTH_W    = 11;
	localparam int HEIGHT_W   = 12;
	localparam int CNT_W      = 23;
	localparam int LEAD_W     = WIDTH_W + 1;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 12;

	localparam logic [WIDTH_W-1:0]  WIDTH_RESET    = 11'd640;
	localparam logic [HEIGHT_W-1:0] HEIGHT_RESET   = 12'd480;
	localparam logic [CNT_W-1:0]    TOTAL_M1_RESET = CNT_W'(640 * 480 - 1);
	localparam logic [WIDTH_W-1:0]  MAX_WIDTH      = WIDTH_W'(MAX_LINE);

	// Iterative divider used to rebuild the output position after a register write
	localparam int DIV_STEPS = CNT_W;
	localparam int DIV_CNT_W = $clog2(DIV_STEPS);

	// Kernel arithmetic: row sums, channel sums, and division by 273 via reciprocal
	localparam int KW_W        = 6;
	localparam int ROW_W       = 15;
	localparam int SUM_W       = 17;
	localparam int RECIP_W     = 17;
	localparam int PROD_W      = SUM_W + RECIP_W;
	localparam int RECIP_SHIFT = 25;
	localparam logic [RECIP_W-1:0] RECIP_MUL = 17'd122911;

	localparam logic [KW_W-1:0] KERNEL_W [KSIDE][KSIDE] = '{
		'{6'd1, 6'd4,  6'd7,  6'd4,  6'd1},
		'{6'd4, 6'd16, 6'd26, 6'd16, 6'd4},
		'{6'd7, 6'd26, 6'd41, 6'd26, 6'd7},
		'{6'd4, 6'd16, 6'd26, 6'd16, 6'd4},
		'{6'd1, 6'd4,  6'd7,  6'd4,  6'd1}
	};

	typedef logic [PIX_W-1:0] pixel_t;
	typedef logic [KSIDE-1:0][PIX_W-1:0] column_t;

	// Per-item control that travels with the pixel column
	typedef struct packed {
		logic             emit;
		logic             last;
		logic [KSIDE-1:0] col_ok;
		logic [KSIDE-1:0] row_ok;
	} item_ctrl_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_IMAGE_WIDTH  = 1'b0,
		REG_IMAGE_HEIGHT = 1'b1
	} cfg_reg_t;

endpackage

@@ hw/rtl/gbr_div.sv @@
// Restoring divider, one quotient bit per cycle, for the output position rebuild.
`timescale 1ns / 1ps

module gbr_div import gbr_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic [CNT_W-1:0]    dividend,
	input  logic [WIDTH_W-1:0]  divisor,
	output logic                busy,
	output logic [CNT_W-1:0]    quotient,
	output logic [LINE_AW-1:0]  remainder
);

	logic                 running_q;
	logic [DIV_CNT_W-1:0] step_q;
	logic [CNT_W-1:0]     acc_q;
	logic [LINE_AW-1:0]   rem_q;
	logic [WIDTH_W-1:0]   trial;
	logic                 fits;
	logic [WIDTH_W-1:0]   diff;

	// Trial subtraction for the next quotient bit
	always_comb begin
		trial = {rem_q, acc_q[CNT_W-1]};
		fits  = trial >= divisor;
		diff  = trial - divisor;
	end

	// Step control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			running_q <= 1'b0;
			step_q    <= '0;
		end else if (start) begin
			running_q <= 1'b1;
			step_q    <= DIV_CNT_W'(DIV_STEPS - 1);
		end else if (running_q) begin
			if (step_q == '0) begin
				running_q <= 1'b0;
			end else begin
				step_q <= step_q - DIV_CNT_W'(1);
			end
		end
	end

	// Datapath: dividend bits shift out as quotient bits shift in
	always_ff @(posedge clk) begin
		if (start) begin
			acc_q <= dividend;
			rem_q <= '0;
		end else if (running_q) begin
			acc_q <= {acc_q[CNT_W-2:0], fits};
			rem_q <= fits ? diff[LINE_AW-1:0] : trial[LINE_AW-1:0];
		end
	end

	assign busy      = running_q;
	assign quotient  = acc_q;
	assign remainder = rem_q;

endmodule

@@ hw/rtl/gbr_ctrl.sv @@
// Configuration registers, raster and output position counters, per-item control.
`timescale 1ns / 1ps

module gbr_ctrl import gbr_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  accept,
	output logic                  busy,
	output logic [LINE_AW-1:0]    rd_col,
	output item_ctrl_t            item
);

	localparam int CY_EXT_W = CNT_W + 1;

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_PREP = 3'b010,
		ST_DIV  = 3'b100
	} cfg_state_t;

	cfg_state_t            state_q;
	logic [WIDTH_W-1:0]    width_q;
	logic [HEIGHT_W-1:0]   height_q;
	logic [CNT_W-1:0]      total_m1_q;
	logic [CNT_W-1:0]      count_q;
	logic [LINE_AW-1:0]    icol_q;
	logic [CNT_W-1:0]      p_q;
	logic [LINE_AW-1:0]    cx_q;
	logic [CNT_W-1:0]      cy_q;

	logic [WIDTH_W-1:0]    eff_w;
	logic [HEIGHT_W-1:0]   eff_h;
	logic [LEAD_W-1:0]     lead;
	logic [CNT_W-1:0]      lead_ext;
	logic [CNT_W-1:0]      p_new;
	logic [LINE_AW-1:0]    col_cur;
	logic [WIDTH_W-1:0]    col_inc;
	logic [LINE_AW-1:0]    col_next;
	logic [WIDTH_W-1:0]    cx_inc;
	logic                  emit;
	logic                  last;
	logic                  div_busy;
	logic [CNT_W-1:0]      div_quo;
	logic [LINE_AW-1:0]    div_rem;

	// Effective frame geometry from the raw register values
	always_comb begin
		if (width_q == '0) begin
			eff_w = WIDTH_W'(1);
		end else if (width_q > MAX_WIDTH) begin
			eff_w = MAX_WIDTH;
		end else begin
			eff_w = width_q;
		end
		eff_h    = (height_q == '0) ? HEIGHT_W'(1) : height_q;
		lead     = {eff_w, 1'b0} + LEAD_W'(2);
		lead_ext = CNT_W'(lead);
		p_new    = (count_q >= lead_ext) ? count_q - lead_ext : '0;
	end

	// Input column, clamped to the current width, and its successor
	always_comb begin
		col_cur  = (WIDTH_W'(icol_q) >= eff_w) ? '0 : icol_q;
		col_inc  = WIDTH_W'(col_cur) + WIDTH_W'(1);
		col_next = (col_inc >= eff_w) ? '0 : col_inc[LINE_AW-1:0];
		cx_inc   = WIDTH_W'(cx_q) + WIDTH_W'(1);
	end

	// Control for the item being offered: emission, frame end and border masks.
	// A row is kept only when it lies between the first and the last image row.
	always_comb begin
		emit          = count_q >= lead_ext;
		last          = emit && (p_q >= total_m1_q);
		item.emit     = emit;
		item.last     = last;
		item.col_ok[0] = cx_q >= LINE_AW'(2);
		item.col_ok[1] = cx_q != '0;
		item.col_ok[2] = 1'b1;
		item.col_ok[3] = (WIDTH_W'(cx_q) + WIDTH_W'(1)) < eff_w;
		item.col_ok[4] = (WIDTH_W'(cx_q) + WIDTH_W'(2)) < eff_w;
		item.row_ok[0] = (cy_q >= CNT_W'(2)) &&
			(CY_EXT_W'(cy_q) < (CY_EXT_W'(eff_h) + CY_EXT_W'(2)));
		item.row_ok[1] = (cy_q != '0) &&
			(CY_EXT_W'(cy_q) < (CY_EXT_W'(eff_h) + CY_EXT_W'(1)));
		item.row_ok[2] = CY_EXT_W'(cy_q) < CY_EXT_W'(eff_h);
		item.row_ok[3] = (CY_EXT_W'(cy_q) + CY_EXT_W'(1)) < CY_EXT_W'(eff_h);
		item.row_ok[4] = (CY_EXT_W'(cy_q) + CY_EXT_W'(2)) < CY_EXT_W'(eff_h);
	end

	// Output position is rebuilt from the item count after every register write
	gbr_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (state_q == ST_PREP),
		.dividend  (p_new),
		.divisor   (eff_w),
		.busy      (div_busy),
		.quotient  (div_quo),
		.remainder (div_rem)
	);

	// Register writes, recompute sequence and counter updates per transaction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			width_q    <= WIDTH_RESET;
			height_q   <= HEIGHT_RESET;
			total_m1_q <= TOTAL_M1_RESET;
			count_q    <= '0;
			icol_q     <= '0;
			p_q        <= '0;
			cx_q       <= '0;
			cy_q       <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (cfg_valid) begin
						case (cfg_index)
							REG_IMAGE_WIDTH:  width_q  <= cfg_data[WIDTH_W-1:0];
							REG_IMAGE_HEIGHT: height_q <= cfg_data[HEIGHT_W-1:0];
							default: ;
						endcase
						state_q <= ST_PREP;
					end else if (accept) begin
						count_q <= last ? '0 : count_q + CNT_W'(1);
						icol_q  <= last ? '0 : col_next;
						if (last) begin
							p_q  <= '0;
							cx_q <= '0;
							cy_q <= '0;
						end else if (emit) begin
							p_q <= p_q + CNT_W'(1);
							if (cx_inc == eff_w) begin
								cx_q <= '0;
								cy_q <= cy_q + CNT_W'(1);
							end else begin
								cx_q <= cx_inc[LINE_AW-1:0];
							end
						end
					end
				end
				ST_PREP: begin
					total_m1_q <= CNT_W'(eff_w) * CNT_W'(eff_h) - CNT_W'(1);
					p_q        <= p_new;
					state_q    <= ST_DIV;
				end
				ST_DIV: begin
					if (!div_busy) begin
						cx_q    <= div_rem;
						cy_q    <= div_quo;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign cfg_ready = state_q == ST_IDLE;
	assign busy      = state_q != ST_IDLE;
	assign rd_col    = col_cur;

	// Items are taken only when idle and never together with a register write
	a_accept_idle: assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> (state_q == ST_IDLE && !cfg_valid))
		else $error("pixel transaction accepted during configuration update");

	// Output position agrees with the item count whenever items may arrive
	a_pos_track: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |->
		((count_q >= lead_ext) ? (p_q == count_q - lead_ext) : (p_q == '0)))
		else $error("output position out of step with item count");

	// Output column stays inside the row
	a_cx_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> (WIDTH_W'(cx_q) < eff_w))
		else $error("output column beyond image width");

	// The divider runs only inside its own state
	a_div_state: assert property (@(posedge clk) disable iff (!arst_n)
		div_busy |-> (state_q == ST_DIV))
		else $error("divider running outside recompute");

endmodule

@@ hw/rtl/gbr_line_buf.sv @@
// Four-line pixel store with registered read and the first pipeline stage.
`timescale 1ns / 1ps

module gbr_line_buf import gbr_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                accept,
	input  logic [LINE_AW-1:0]  rd_col,
	input  pixel_t              pixel,
	input  item_ctrl_t          item,
	input  logic                advance,
	output logic                valid_s1,
	output column_t             column,
	output item_ctrl_t          item_s1
);

	logic [STORE_W-1:0] row_store_q [MAX_LINE];
	logic [STORE_W-1:0] rd_s1;
	logic [LINE_AW-1:0] col_s1;
	pixel_t             pix_s1;
	logic [STORE_W-1:0] wr_data;
	logic               bypass;

	// Each line moves up by one: the oldest drops out, the new pixel enters
	always_comb begin
		wr_data = {pix_s1, rd_s1[STORE_W-1:PIX_W]};
		bypass  = advance && (col_s1 == rd_col);
		for (int j = 0; j < STORE_LINES; j++) begin
			column[j] = rd_s1[j*PIX_W +: PIX_W];
		end
		column[KSIDE-1] = pix_s1;
	end

	// Stage valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	// Registered read, forwarding a write to the same column in the same cycle
	always_ff @(posedge clk) begin
		if (accept) begin
			rd_s1   <= bypass ? wr_data : row_store_q[rd_col];
			col_s1  <= rd_col;
			pix_s1  <= pixel;
			item_s1 <= item;
		end
	end

	// Write-back of the shifted column
	always_ff @(posedge clk) begin
		if (advance) begin
			row_store_q[col_s1] <= wr_data;
		end
	end

endmodule

@@ hw/rtl/gbr_filter.sv @@
// Window taps, masked weighted sums, division by 273 and the result register.
`timescale 1ns / 1ps

module gbr_filter import gbr_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        take,
	input  column_t     column,
	input  item_ctrl_t  item_s1,
	output logic        ready,
	output logic        res_valid,
	input  logic        res_stall,
	output logic [7:0]  red_out,
	output logic [7:0]  green_out,
	output logic [7:0]  blue_out,
	output logic [7:0]  alpha_out,
	output logic        frame_last
);

	pixel_t                              win_q [KSIDE][KSIDE];
	logic                                valid_s2;
	item_ctrl_t                          ctrl_s2;
	logic                                valid_s3;
	logic                                last_s3;
	logic [ROW_W-1:0]                    row_sum_s3 [NCHAN][KSIDE];
	logic                                valid_s4;
	logic                                last_s4;
	logic [SUM_W-1:0]                    sum_s4 [NCHAN];
	logic                                res_valid_q;
	logic                                res_last_q;
	logic [NCHAN-1:0][CH_W-1:0]          res_chan_q;

	logic                                rdy_out;
	logic                                rdy_s4;
	logic                                rdy_s3;
	logic [ROW_W-1:0]                    row_sum_d [NCHAN][KSIDE];
	logic [SUM_W-1:0]                    sum_d [NCHAN];
	logic [PROD_W-1:0]                   prod [NCHAN];

	// Stage handshake: a stage moves when it is empty or its successor moves
	always_comb begin
		rdy_out = !res_valid_q || !res_stall;
		rdy_s4  = !valid_s4 || rdy_out;
		rdy_s3  = !valid_s3 || rdy_s4;
		ready   = !valid_s2 || rdy_s3;
	end

	// Masked weighted row sums over the window
	always_comb begin
		for (int c = 0; c < NCHAN; c++) begin
			for (int j = 0; j < KSIDE; j++) begin
				row_sum_d[c][j] = '0;
				for (int i = 0; i < KSIDE; i++) begin
					if (ctrl_s2.col_ok[i] && ctrl_s2.row_ok[j]) begin
						row_sum_d[c][j] = row_sum_d[c][j] +
							ROW_W'(win_q[j][i][c*CH_W +: CH_W]) * ROW_W'(KERNEL_W[j][i]);
					end
				end
			end
		end
	end

	// Channel totals and reciprocal products
	always_comb begin
		for (int c = 0; c < NCHAN; c++) begin
			sum_d[c] = '0;
			for (int j = 0; j < KSIDE; j++) begin
				sum_d[c] = sum_d[c] + SUM_W'(row_sum_s3[c][j]);
			end
			prod[c] = PROD_W'(sum_s4[c]) * PROD_W'(RECIP_MUL);
		end
	end

	// Window shift: every item pushes one column in on the right
	always_ff @(posedge clk) begin
		if (take) begin
			for (int j = 0; j < KSIDE; j++) begin
				for (int i = 0; i < KSIDE - 1; i++) begin
					win_q[j][i] <= win_q[j][i+1];
				end
				win_q[j][KSIDE-1] <= column[j];
			end
			ctrl_s2 <= item_s1;
		end
	end

	// Stage valids; only items that produce a result stay valid past the window
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2    <= 1'b0;
			valid_s3    <= 1'b0;
			valid_s4    <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (take) begin
				valid_s2 <= item_s1.emit;
			end else if (rdy_s3) begin
				valid_s2 <= 1'b0;
			end
			if (rdy_s3) begin
				valid_s3 <= valid_s2;
			end
			if (rdy_s4) begin
				valid_s4 <= valid_s3;
			end
			if (rdy_out) begin
				res_valid_q <= valid_s4;
			end
		end
	end

	// Payload registers of the sum stages and the result register
	always_ff @(posedge clk) begin
		if (rdy_s3 && valid_s2) begin
			row_sum_s3 <= row_sum_d;
			last_s3    <= ctrl_s2.last;
		end
		if (rdy_s4 && valid_s3) begin
			sum_s4  <= sum_d;
			last_s4 <= last_s3;
		end
		if (rdy_out && valid_s4) begin
			for (int c = 0; c < NCHAN; c++) begin
				res_chan_q[c] <= prod[c][RECIP_SHIFT +: CH_W];
			end
			res_last_q <= last_s4;
		end
	end

	assign res_valid  = res_valid_q;
	assign red_out    = res_chan_q[0];
	assign green_out  = res_chan_q[1];
	assign blue_out   = res_chan_q[2];
	assign alpha_out  = res_chan_q[3];
	assign frame_last = res_last_q;

endmodule

@@ hw/rtl/gaussian_blur_5x5_rgba_core.sv @@
// Top level of the streaming 5x5 Gaussian blur (kernel weight sum 273) for RGBA pixels.
// A result goes through the line-store read, window, row-sum, channel-sum and result registers.
// Throughput: one pixel per cycle unless res_stall or a register write holds it off, set by
// one line-store read and write per item. After a register write, pixels are held off while
// the bit-serial divider rebuilds the output position. Reset is asynchronous and active low; the
// line store is not cleared, and frame counters restart at zero with width 640 and height 480.
`timescale 1ns / 1ps

module gaussian_blur_5x5_rgba_core import gbr_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  px_valid,
	output logic                  px_stall,
	input  logic                  action,
	input  logic [7:0]            red_in,
	input  logic [7:0]            green_in,
	input  logic [7:0]            blue_in,
	input  logic [7:0]            alpha_in,
	output logic                  res_valid,
	input  logic                  res_stall,
	output logic [7:0]            red_out,
	output logic [7:0]            green_out,
	output logic [7:0]            blue_out,
	output logic [7:0]            alpha_out,
	output logic                  frame_last
);

	logic               accept;
	logic               busy;
	logic [LINE_AW-1:0] rd_col;
	item_ctrl_t         item;
	pixel_t             pixel;
	logic               valid_s1;
	column_t            column;
	item_ctrl_t         item_s1;
	logic               flt_ready;
	logic               take;

	// Pixel transaction handshake; drain items enter as zero pixels
	always_comb begin
		take     = valid_s1 && flt_ready;
		px_stall = (valid_s1 && !flt_ready) || busy || cfg_valid;
		accept   = px_valid && !px_stall;
		pixel    = action ? '0 : {alpha_in, blue_in, green_in, red_in};
	end

	gbr_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.accept    (accept),
		.busy      (busy),
		.rd_col    (rd_col),
		.item      (item)
	);

	gbr_line_buf u_line_buf (
		.clk      (clk),
		.arst_n   (arst_n),
		.accept   (accept),
		.rd_col   (rd_col),
		.pixel    (pixel),
		.item     (item),
		.advance  (take),
		.valid_s1 (valid_s1),
		.column   (column),
		.item_s1  (item_s1)
	);

	gbr_filter u_filter (
		.clk        (clk),
		.arst_n     (arst_n),
		.take       (take),
		.column     (column),
		.item_s1    (item_s1),
		.ready      (flt_ready),
		.res_valid  (res_valid),
		.res_stall  (res_stall),
		.red_out    (red_out),
		.green_out  (green_out),
		.blue_out   (blue_out),
		.alpha_out  (alpha_out),
		.frame_last (frame_last)
	);

endmodule

@@ tb/tb_gaussian_blur_5x5_rgba_core.sv @@
// Self-checking regression for the streaming 5x5 RGBA Gaussian blur core against a built-in predictor.
`timescale 1ns / 1ps

module tb_gaussian_blur_5x5_rgba_core import gbr_pkg::*; ();

	localparam int WEIGHT_TOTAL  = 273;
	localparam int RANDOM_ITEMS  = 900;
	localparam int FILL_WIDTH    = 100;
	localparam int CYCLE_LIMIT   = 1000000;
	localparam int HOLD_CYCLES   = 400;
	localparam int SETTLE_CYCLES = 8;

	localparam int GAUSS_W [KSIDE][KSIDE] = '{
		'{1, 4, 7, 4, 1},
		'{4, 16, 26, 16, 4},
		'{7, 26, 41, 26, 7},
		'{4, 16, 26, 16, 4},
		'{1, 4, 7, 4, 1}
	};

	typedef struct packed {
		logic       drain;
		logic [7:0] r;
		logic [7:0] g;
		logic [7:0] b;
		logic [7:0] a;
	} px_item_t;

	typedef struct packed {
		logic [7:0] r;
		logic [7:0] g;
		logic [7:0] b;
		logic [7:0] a;
		logic       last;
	} blur_px_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = REG_IMAGE_WIDTH;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic                  px_valid = 1'b0;
	logic                  px_stall;
	logic                  action = 1'b0;
	logic [7:0]            red_in = '0;
	logic [7:0]            green_in = '0;
	logic [7:0]            blue_in = '0;
	logic [7:0]            alpha_in = '0;
	logic                  res_valid;
	logic                  res_stall = 1'b0;
	logic [7:0]            red_out;
	logic [7:0]            green_out;
	logic [7:0]            blue_out;
	logic [7:0]            alpha_out;
	logic                  frame_last;

	// Stimulus and expectation stores
	px_item_t pending_px [$];
	blur_px_t expected_px [$];
	int       items_queued = 0;
	int       items_taken = 0;
	int       mismatches = 0;
	int       cycle_count = 0;

	// Predictor state: line store, window, frame position and geometry
	bit [PIX_W-1:0] line_mem [STORE_LINES][MAX_LINE];
	bit [PIX_W-1:0] win [KSIDE][KSIDE];
	int             frame_items = 0;
	int             in_col = 0;
	int             line_width = 640;
	int             frame_rows = 480;

	// Sender and receiver pacing
	int tx_wait = 0;
	bit tx_calm = 1'b0;
	int rx_left = 0;
	bit rx_calm = 1'b0;
	bit rx_hold = 1'b0;
	bit hold_arm = 1'b0;

	gaussian_blur_5x5_rgba_core u_top (.*);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Pause length: mostly none or short, now and then long.
	function automatic int draw_pause();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 88) return $urandom_range(1, 3);
		if (r < 97) return $urandom_range(4, 10);
		return $urandom_range(11, 40);
	endfunction

	// Advance the blur predictor by one accepted pixel transaction.
	task automatic blur_accept(input px_item_t it);
		int w, h, col, n, lead, p, cy, cx, ty, tx, j, i, dy, dx, c;
		bit [PIX_W-1:0] pix, tap;
		bit [PIX_W-1:0] column [KSIDE];
		int acc [NCHAN];
		blur_px_t res;
		w = (line_width == 0) ? 1 : ((line_width > MAX_LINE) ? MAX_LINE : line_width);
		h = (frame_rows == 0) ? 1 : frame_rows;
		col = (in_col >= w) ? 0 : in_col;
		n = frame_items;
		lead = 2 * w + 2;
		pix = it.drain ? '0 : {it.a, it.b, it.g, it.r};
		items_taken++;

		// Shift the column through the line store, oldest row first.
		for (j = 0; j < STORE_LINES; j++)
			column[j] = line_mem[j][col];
		column[KSIDE-1] = pix;
		for (j = 0; j < STORE_LINES; j++)
			line_mem[j][col] = column[j + 1];
		for (j = 0; j < KSIDE; j++) begin
			for (i = 0; i < KSIDE - 1; i++)
				win[j][i] = win[j][i + 1];
			win[j][KSIDE-1] = column[j];
		end

		frame_items = (n + 1) & 'h7FFFFF;
		col = col + 1;
		in_col = (col >= w) ? 0 : (col & 'h3FF);
		if (n < lead)
			return;

		// Weighted sum over the taps that lie inside the image.
		p = n - lead;
		cy = p / w;
		cx = p % w;
		acc = '{default: 0};
		for (dy = -2; dy <= 2; dy++) begin
			ty = cy + dy;
			if (ty >= 0 && ty < h) begin
				for (dx = -2; dx <= 2; dx++) begin
					tx = cx + dx;
					if (tx >= 0 && tx < w) begin
						tap = win[dy + 2][dx + 2];
						for (c = 0; c < NCHAN; c++)
							acc[c] += int'(tap[CH_W*c +: CH_W]) * GAUSS_W[dy + 2][dx + 2];
					end
				end
			end
		end
		res.r = 8'(acc[0] / WEIGHT_TOTAL);
		res.g = 8'(acc[1] / WEIGHT_TOTAL);
		res.b = 8'(acc[2] / WEIGHT_TOTAL);
		res.a = 8'(acc[3] / WEIGHT_TOTAL);
		res.last = (p >= w * h - 1);
		expected_px.push_back(res);
		if (res.last) begin
			frame_items = 0;
			in_col = 0;
		end
	endtask

	task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
		if (want !== got) begin
			$display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
			mismatches++;
		end
	endtask

	task automatic queue_px(input bit drain, input logic [7:0] r, input logic [7:0] g,
			input logic [7:0] b, input logic [7:0] a);
		px_item_t item;
		item.drain = drain;
		item.r = r;
		item.g = g;
		item.b = b;
		item.a = a;
		pending_px.push_back(item);
		items_queued++;
	endtask

	// Random channels, biased toward the extremes now and then.
	task automatic queue_random(input bit drain);
		logic [7:0] ch [NCHAN];
		int c;
		for (c = 0; c < NCHAN; c++)
			ch[c] = ($urandom_range(0, 7) == 0) ? ($urandom_range(0, 1) ? 8'hFF : 8'h00)
				: 8'($urandom);
		queue_px(drain, ch[0], ch[1], ch[2], ch[3]);
	endtask

	// Wait until every queued pixel is taken and every result has come back.
	task automatic settle();
		do
			@(posedge clk);
		while (items_taken != items_queued || expected_px.size() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Write both geometry registers while the core is idle.
	task automatic set_geometry(input int w, input int h);
		settle();
		cfg_valid <= 1'b1;
		cfg_index <= REG_IMAGE_WIDTH;
		cfg_data <= CFG_DATA_W'(w);
		do
			@(posedge clk);
		while (!cfg_ready);
		line_width = w & 'h7FF;
		cfg_index <= REG_IMAGE_HEIGHT;
		cfg_data <= CFG_DATA_W'(h);
		do
			@(posedge clk);
		while (!cfg_ready);
		frame_rows = h & 'hFFF;
		cfg_valid <= 1'b0;
	endtask

	// Feed drain items one at a time until the frame counters restart.
	task automatic close_frame();
		settle();
		while (frame_items != 0) begin
			queue_random(1'b1);
			settle();
		end
	endtask

	// Pixel sender: holds a stalled transaction, otherwise pops the next one after its gap.
	always @(posedge clk) begin : px_drive
		px_item_t nxt;
		if (arst_n) begin
			if (px_valid && !px_stall)
				blur_accept(px_item_t'({action, red_in, green_in, blue_in, alpha_in}));
			if (!px_valid || !px_stall) begin
				if (tx_wait > 0) begin
					px_valid <= 1'b0;
					tx_wait <= tx_wait - 1;
				end else if (pending_px.size() != 0) begin
					nxt = pending_px.pop_front();
					px_valid <= 1'b1;
					action <= nxt.drain;
					red_in <= nxt.r;
					green_in <= nxt.g;
					blue_in <= nxt.b;
					alpha_in <= nxt.a;
					tx_wait <= tx_calm ? 0 : draw_pause();
					if ($urandom_range(0, 199) == 0)
						tx_calm <= !tx_calm;
				end else begin
					px_valid <= 1'b0;
				end
			end
		end
	end

	// Result receiver stall: random stretches, calm periods, and the long hold-off.
	always @(posedge clk) begin
		if (rx_hold) begin
			res_stall <= 1'b1;
		end else if (rx_left > 0) begin
			res_stall <= 1'b1;
			rx_left <= rx_left - 1;
		end else begin
			res_stall <= 1'b0;
			if (!rx_calm && $urandom_range(0, 3) == 0)
				rx_left <= draw_pause();
		end
		if ($urandom_range(0, 299) == 0)
			rx_calm <= !rx_calm;
	end

	// Hold off the receiver once results flow, so the core backs up into its input.
	initial begin : rx_backpressure
		wait (hold_arm);
		while (expected_px.size() == 0)
			@(posedge clk);
		rx_hold <= 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		rx_hold <= 1'b0;
	end

	// Compare each result transaction with the oldest expectation.
	always @(posedge clk) begin : res_check
		blur_px_t want;
		if (arst_n && res_valid && !res_stall) begin
			if (expected_px.size() == 0) begin
				$display("%0t ns: result transaction with nothing expected, actual rgba %h %h %h %h last %b",
					$time, red_out, green_out, blue_out, alpha_out, frame_last);
				mismatches++;
			end else begin
				want = expected_px.pop_front();
				check_field("red_out", want.r, red_out);
				check_field("green_out", want.g, green_out);
				check_field("blue_out", want.b, blue_out);
				check_field("alpha_out", want.a, alpha_out);
				check_field("frame_last", 8'(want.last), 8'(frame_last));
			end
		end
	end

	// Watchdog on the whole run.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("gaussian_blur_5x5_rgba_core regression: fail");
			$finish;
		end
	end

	initial begin : stimulus
		int w, h, span, k, random_items;
		bit cut;
		random_items = 0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Fill all four lines over the widest row of the random frames below; the tall frame keeps the
		// end of frame out of reach.
		set_geometry(FILL_WIDTH, 4095);
		hold_arm = 1'b1;
		for (k = 0; k < STORE_LINES * FILL_WIDTH; k++)
			queue_random($urandom_range(0, 19) == 0);

		// Width data with all bits set clamps to the widest line; nothing is emitted yet.
		set_geometry(12'hFFF, 4095);
		for (k = 0; k < 6; k++)
			queue_random(1'b0);

		// Zero width and height count as one; the change lands mid-frame and ends it.
		set_geometry(0, 0);
		queue_random(1'b0);
		// A whole one-pixel frame, with drain items carrying full-scale data.
		queue_px(1'b0, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
		for (k = 0; k < 4; k++)
			queue_px(1'b1, 8'hFF, 8'hFF, 8'hFF, 8'hFF);

		// Channel extremes on a small frame, and a real pixel in a drain slot.
		set_geometry(3, 2);
		queue_px(1'b0, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
		queue_px(1'b0, 8'h00, 8'h00, 8'h00, 8'h00);
		queue_px(1'b0, 8'hFF, 8'h00, 8'hFF, 8'h00);
		queue_px(1'b0, 8'h00, 8'hFF, 8'h00, 8'hFF);
		queue_px(1'b0, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
		queue_px(1'b0, 8'h80, 8'h7F, 8'h01, 8'hFE);
		for (k = 0; k < 3; k++)
			queue_px(1'b1, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
		queue_px(1'b0, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
		for (k = 0; k < 4; k++)
			queue_random(1'b1);

		// Full line width, cut short by a geometry whose frame is already over.
		set_geometry(MAX_LINE, 1);
		for (k = 0; k < 6; k++)
			queue_random(1'b0);
		set_geometry(1, 1);
		close_frame();

		// Random frames: mostly well formed, a few cut short and reconfigured mid-frame.
		while (random_items < RANDOM_ITEMS) begin
			case ($urandom_range(0, 19))
				0: begin
					w = $urandom_range(41, FILL_WIDTH);
					h = $urandom_range(1, 2);
				end
				1, 2, 3, 4, 5: begin
					w = $urandom_range(9, 40);
					h = $urandom_range(1, 4);
				end
				default: begin
					w = $urandom_range(1, 8);
					h = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 12) : $urandom_range(1, 6);
				end
			endcase
			span = w * h + 2 * w + 2;
			cut = ($urandom_range(0, 9) == 0);
			if (cut)
				span = $urandom_range(1, span - 1);
			set_geometry(w, h);
			for (k = 0; k < span; k++) begin
				if (k < w * h)
					queue_random($urandom_range(0, 29) == 0);
				else
					queue_random($urandom_range(0, 14) != 0);
			end
			random_items += span;
			if (cut) begin
				set_geometry($urandom_range(1, 6), $urandom_range(1, 4));
				close_frame();
			end
		end

		settle();
		if (mismatches == 0)
			$display("gaussian_blur_5x5_rgba_core regression: pass");
		else
			$display("gaussian_blur_5x5_rgba_core regression: fail");
		$finish;
	end

endmodule
